// ----- src/sensor_frame_deframer_core_assert.svh -----
// Assertion macros used by the deframer datapath.
`ifndef SENSOR_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTH
`define SFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define SFD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/sfd_pkg.sv -----
package sfd_pkg;

    localparam int SFD_MAX_SENSORS = 32;
    localparam int SFD_CFG_W       = 6;
    localparam int SFD_BYTE_W      = 8;
    localparam int SFD_IDX_W       = 5;

    localparam logic [SFD_CFG_W-1:0]  SFD_CFG_RESET = 6'd32;
    localparam logic [SFD_BYTE_W-1:0] SFD_SYNC_BYTE = 8'hFF;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_frame;
        logic start_err;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic good;
        logic bad;
        logic out_free;
        logic last;
    } t_status;

endpackage

// ----- src/sfd_ram.sv -----
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sfd_ctrl.sv -----
module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rx_valid,
    output logic    o_rx_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_rx_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_rx_stall = 1'b0;
                if (i_rx_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.good) begin
                        o_cmd.start_frame = 1'b1;
                        n_state = ST_EMIT;
                    end else if (i_status.bad) begin
                        o_cmd.start_err = 1'b1;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/sfd_datapath.sv -----
module sfd_datapath
    import sfd_pkg::*;
#(
    parameter int MAX_SENSORS = SFD_MAX_SENSORS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [SFD_BYTE_W-1:0] i_rx_byte,
    input  logic                  i_cfg_valid,
    input  logic [SFD_CFG_W-1:0]  i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_res_stall,
    output logic                  o_res_valid,
    output logic [SFD_IDX_W-1:0]  o_sensor_index,
    output logic [SFD_BYTE_W-1:0] o_activation,
    output logic                  o_frame_error,
    output logic                  o_last
);

    `include "sensor_frame_deframer_core_assert.svh"

    localparam int AW   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CNTW = $clog2(MAX_SENSORS + 1);
    localparam int POSW = $clog2(MAX_SENSORS + 2);

    logic [SFD_CFG_W-1:0]  r_cfg;
    logic                  r_aligned;
    logic [SFD_BYTE_W-1:0] r_prev;
    logic [POSW-1:0]       r_pos;
    logic [AW-1:0]         r_k;
    logic                  r_err_mode;

    logic                  r_out_valid;
    logic [SFD_IDX_W-1:0]  r_idx;
    logic [SFD_BYTE_W-1:0] r_act;
    logic                  r_err_out;
    logic                  r_last;

    logic [CNTW-1:0]       eff_count;
    logic [POSW-1:0]       count_pos;
    logic                  sync_pair;
    logic                  pos_lt;
    logic                  pos_eq;
    logic                  trailer;
    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [SFD_BYTE_W-1:0] ram_rdata;
    logic                  out_take;

    always_comb begin
        if (r_cfg == '0) begin
            eff_count = CNTW'(1);
        end else if (int'(r_cfg) > MAX_SENSORS) begin
            eff_count = CNTW'(MAX_SENSORS);
        end else begin
            eff_count = CNTW'(r_cfg);
        end
    end

    assign count_pos = POSW'(eff_count);
    assign sync_pair = (r_prev == SFD_SYNC_BYTE) && (i_rx_byte == SFD_SYNC_BYTE);
    assign pos_lt    = r_pos < count_pos;
    assign pos_eq    = r_pos == count_pos;
    assign trailer   = r_aligned && !pos_lt && !pos_eq;

    assign o_status.good     = trailer && sync_pair;
    assign o_status.bad      = trailer && !sync_pair;
    assign out_take          = r_out_valid && !i_res_stall;
    assign o_status.out_free = !r_out_valid || !i_res_stall;
    assign o_status.last     = r_err_mode || ((CNTW'(r_k) + CNTW'(1)) == eff_count);

    assign ram_we    = i_cmd.accept && r_aligned && pos_lt;
    assign ram_re    = i_cmd.start_frame || (i_cmd.load && !o_status.last);
    assign ram_raddr = i_cmd.start_frame ? '0 : AW'(r_k + AW'(1));

    sfd_ram #(
        .WIDTH (SFD_BYTE_W),
        .DEPTH (MAX_SENSORS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= SFD_CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aligned <= 1'b0;
            r_prev    <= '0;
            r_pos     <= '0;
        end else if (i_cmd.accept) begin
            r_prev <= i_rx_byte;
            if (!r_aligned) begin
                if (sync_pair) begin
                    r_aligned <= 1'b1;
                    r_pos     <= '0;
                end
            end else if (pos_lt || pos_eq) begin
                r_pos <= r_pos + POSW'(1);
            end else begin
                r_pos <= '0;
                if (!sync_pair) begin
                    r_aligned <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_frame || i_cmd.start_err) begin
            r_k        <= '0;
            r_err_mode <= i_cmd.start_err;
        end else if (i_cmd.load && !o_status.last) begin
            r_k <= r_k + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx     <= r_err_mode ? '0 : SFD_IDX_W'(r_k);
            r_act     <= r_err_mode ? '0 : ram_rdata;
            r_err_out <= r_err_mode;
            r_last    <= o_status.last;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_sensor_index = r_idx;
    assign o_activation   = r_act;
    assign o_frame_error  = r_err_out;
    assign o_last         = r_last;

    `SFD_ASSERT_NOW(a_load_free, i_clk, i_rst_n, i_cmd.load, o_status.out_free)
    `SFD_ASSERT_NOW(a_wr_aligned, i_clk, i_rst_n, ram_we, r_aligned && !trailer)
    `SFD_ASSERT_NOW(a_err_form, i_clk, i_rst_n, r_out_valid && r_err_out,
                    r_last && (r_idx == '0) && (r_act == '0))
    `SFD_ASSERT_NEXT(a_start_idle, i_clk, i_rst_n, i_cmd.start_frame || i_cmd.start_err,
                     r_k == '0)

endmodule

// ----- src/sensor_frame_deframer_core.sv -----
// Sensor frame deframer.
// Input channel (i_rx_valid / o_rx_stall / i_rx_byte): one serial byte per
// transfer. A frame is sensor_count activation bytes followed by two 0xFF
// sync bytes; the block hunts for a 0xFF pair before taking a frame.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes
// sensor_count; write only while idle. o_cfg_ready is always high.
// Result channel (o_res_valid / i_res_stall): on a good trailer one result
// per sensor (sensor_index, activation), o_last on the highest index; on a
// bad trailer one result with o_frame_error and o_last set.
// Throughput: a byte that causes no result does not stall the input. A good
// trailer byte starts a buffer RAM read that primes the output register, then
// one result is loaded per cycle while the receiver does not stall; input
// stalls until the last result is loaded. A bad trailer byte stalls input
// until its error result is loaded. o_res_valid is set by each load.
// Receiver stall holds the output register and pauses the emit sequence.
// Reset (synchronous, active low) clears alignment, position, the previous
// byte and the output valid, and sets sensor_count to 32. The frame buffer
// is not cleared.
module sensor_frame_deframer_core
    import sfd_pkg::*;
#(
    parameter int MAX_SENSORS = SFD_MAX_SENSORS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    output logic                  o_rx_stall,
    input  logic [SFD_BYTE_W-1:0] i_rx_byte,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SFD_CFG_W-1:0]  i_cfg_data,
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output logic [SFD_IDX_W-1:0]  o_sensor_index,
    output logic [SFD_BYTE_W-1:0] o_activation,
    output logic                  o_frame_error,
    output logic                  o_last
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    sfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sfd_datapath #(
        .MAX_SENSORS (MAX_SENSORS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_res_stall    (i_res_stall),
        .o_res_valid    (o_res_valid),
        .o_sensor_index (o_sensor_index),
        .o_activation   (o_activation),
        .o_frame_error  (o_frame_error),
        .o_last         (o_last)
    );

endmodule

// ----- tb/sv/tb_sensor_frame_deframer_core.sv -----
`timescale 1ns / 100ps

module tb_sensor_frame_deframer_core;
    import sfd_pkg::*;

    typedef struct packed {
        logic [SFD_IDX_W-1:0]  sensor_index;
        logic [SFD_BYTE_W-1:0] activation;
        logic                  frame_error;
        logic                  is_last;
    } t_frame_result;

    class t_result_tracker;
        t_frame_result         pending_results[$];
        logic [SFD_CFG_W-1:0]  count_reg;
        bit                    in_frame;
        logic [SFD_BYTE_W-1:0] prior_byte;
        int                    slot;
        logic [SFD_BYTE_W-1:0] act_mem [SFD_MAX_SENSORS];
        bit                    mem_valid [SFD_MAX_SENSORS];
        int                    errors;

        function new();
            count_reg  = SFD_CFG_RESET;
            in_frame   = 1'b0;
            prior_byte = '0;
            slot       = 0;
            errors     = 0;
            foreach (mem_valid[k]) begin
                mem_valid[k] = 1'b0;
                act_mem[k]   = '0;
            end
        endfunction

        function int clamp_count(int v);
            int c;
            c = v % (1 << SFD_CFG_W);
            if (c < 1) c = 1;
            if (c > SFD_MAX_SENSORS) c = SFD_MAX_SENSORS;
            return c;
        endfunction

        function int eff_count();
            return clamp_count(count_reg);
        endfunction

        // a new count must not make the next good trailer report a never-written slot
        function bit can_resize(int v);
            int n;
            int lim;
            n = clamp_count(v);
            if (!in_frame) return 1'b1;
            lim = (slot < n) ? slot : n;
            for (int k = 0; k < lim; k++) begin
                if (!mem_valid[k]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_byte(logic [SFD_BYTE_W-1:0] b);
            int n;
            t_frame_result r;
            n = eff_count();
            if (!in_frame) begin
                if (prior_byte == SFD_SYNC_BYTE && b == SFD_SYNC_BYTE) begin
                    in_frame = 1'b1;
                    slot     = 0;
                end
            end else if (slot < n) begin
                act_mem[slot]   = b;
                mem_valid[slot] = 1'b1;
                slot++;
            end else if (slot == n) begin
                slot++;
            end else begin
                if (prior_byte == SFD_SYNC_BYTE && b == SFD_SYNC_BYTE) begin
                    for (int k = 0; k < n; k++) begin
                        r.sensor_index = k[SFD_IDX_W-1:0];
                        r.activation   = act_mem[k];
                        r.frame_error  = 1'b0;
                        r.is_last      = (k == n - 1);
                        pending_results = {pending_results, r};
                    end
                end else begin
                    r.sensor_index = '0;
                    r.activation   = '0;
                    r.frame_error  = 1'b1;
                    r.is_last      = 1'b1;
                    pending_results = {pending_results, r};
                    in_frame = 1'b0;
                end
                slot = 0;
            end
            prior_byte = b;
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result expected none actual %s %0d %0d %0b %0b",
                         $time, "idx/act/err/last", got.sensor_index, got.activation,
                         got.frame_error, got.is_last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("sensor_index", 8'(want.sensor_index), 8'(got.sensor_index));
            check_field("activation", want.activation, got.activation);
            check_field("frame_error", 8'(want.frame_error), 8'(got.frame_error));
            check_field("last", 8'(want.is_last), 8'(got.is_last));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  rx_valid;
    logic                  rx_stall;
    logic [SFD_BYTE_W-1:0] rx_byte;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SFD_CFG_W-1:0]  cfg_data;
    logic                  res_valid;
    logic                  res_stall;
    logic [SFD_IDX_W-1:0]  sensor_index;
    logic [SFD_BYTE_W-1:0] activation;
    logic                  frame_error;
    logic                  last_flag;

    t_result_tracker sb;
    bit rx_idle;
    bit res_idle;
    int bytes_sent;

    sensor_frame_deframer_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .o_sensor_index (sensor_index),
        .o_activation   (activation),
        .o_frame_error  (frame_error),
        .o_last         (last_flag)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_byte(input logic [SFD_BYTE_W-1:0] b, input bit counted);
        int gap;
        gap = rx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            rx_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid = 1'b1;
        rx_byte  = b;
        do @(posedge clk); while (rx_stall !== 1'b0);
        sb.take_byte(b);
        if (counted) bytes_sent++;
        @(negedge clk);
    endtask

    // drain all results, then hold for the block's internal latency
    task automatic settle_block();
        rx_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_count(input logic [SFD_CFG_W-1:0] v);
        settle_block();
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.count_reg = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [SFD_BYTE_W-1:0] data_byte();
        return ($urandom_range(0, 7) == 0) ? SFD_SYNC_BYTE : SFD_BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic run_frame();
        int kind;
        int n;
        logic [SFD_BYTE_W-1:0] t1;
        logic [SFD_BYTE_W-1:0] t2;
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(SFD_BYTE_W'($urandom_range(0, 255)), 1'b0);
            return;
        end
        if (!sb.in_frame) begin
            if (kind == 1) send_byte(SFD_BYTE_W'($urandom_range(0, 255)), 1'b0);
            send_byte(SFD_SYNC_BYTE, 1'b1);
            send_byte(SFD_SYNC_BYTE, 1'b1);
        end
        n = sb.eff_count() - ((kind == 2) ? 1 : 0);
        while (sb.in_frame && sb.slot < n) send_byte(data_byte(), 1'b1);
        t1 = SFD_SYNC_BYTE;
        t2 = SFD_SYNC_BYTE;
        if (kind == 3) t2 = SFD_BYTE_W'($urandom_range(0, 254));
        if (kind == 4) t1 = SFD_BYTE_W'($urandom_range(0, 254));
        send_byte(t1, 1'b1);
        send_byte(t2, 1'b1);
        if (kind == 5) settle_block();
    endtask

    initial begin
        int gap;
        t_frame_result got;
        res_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            gap = res_idle ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                res_stall = 1'b1;
                repeat (gap) @(negedge clk);
                res_stall = 1'b0;
            end
            do @(posedge clk); while (res_valid !== 1'b1);
            got.sensor_index = sensor_index;
            got.activation   = activation;
            got.frame_error  = frame_error;
            got.is_last      = last_flag;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    initial begin
        logic [SFD_BYTE_W-1:0] opening_bytes [25];
        int count_plan [6];
        int phase;
        int phase_end;
        int v;
        rst_n      = 1'b0;
        rx_valid   = 1'b0;
        rx_byte    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        rx_idle    = 1'b1;
        res_idle   = 1'b1;
        bytes_sent = 0;
        sb = new();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // good frame after a sync run, bad second trailer, bad first trailer
        // whose closing 0xFF starts the next sync pair, then a good frame
        opening_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'hFF,
                          8'h55, 8'hAA, 8'h01, 8'hFF, 8'h00,
                          8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h7E, 8'hFF,
                          8'hFF, 8'h01, 8'h02, 8'h03, 8'hFF, 8'hFF};
        write_count(SFD_CFG_W'(3));
        foreach (opening_bytes[k]) send_byte(opening_bytes[k], 1'b0);

        count_plan = '{63, 0, 1, 32, 2, 17};
        phase = 0;
        while (bytes_sent < 420) begin
            v = (phase < 6) ? count_plan[phase] : $urandom_range(0, 63);
            if (!sb.can_resize(v)) v = sb.count_reg;
            write_count(SFD_CFG_W'(v));
            rx_idle  = (phase == 0) || ($urandom_range(0, 3) != 0);
            res_idle = (phase == 0) || ($urandom_range(0, 3) != 0);
            phase_end = bytes_sent + $urandom_range(30, 70);
            while (bytes_sent < phase_end && bytes_sent < 420) run_frame();
            phase++;
        end

        settle_block();
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
